@@ hw/rtl/faofs_pkg.sv @@
// Shared types and codes of the float ALU operand fetch and store block.
`default_nettype none

package faofs_pkg;

    typedef logic [31:0] word_t;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] KIND_EXEC   = 2'd0;
    localparam logic [1:0] KIND_HWRITE = 2'd1;
    localparam logic [1:0] KIND_HREAD  = 2'd2;

    // Storage spaces.
    localparam logic [1:0] SPACE_CONST  = 2'd0;
    localparam logic [1:0] SPACE_REG    = 2'd1;
    localparam logic [1:0] SPACE_GLOBAL = 2'd2;
    localparam logic [1:0] SPACE_SHARED = 2'd3;

    // Instruction opcodes.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOV = 3'd4;
    localparam logic [2:0] OP_NEG = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DIVZERO = 3'd1;
    localparam logic [2:0] ST_BADOP   = 3'd2;
    localparam logic [2:0] ST_CONSTDST = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    // Operations of the floating-point unit.
    localparam logic [1:0] FOP_ADD = 2'd0;
    localparam logic [1:0] FOP_SUB = 2'd1;
    localparam logic [1:0] FOP_MUL = 2'd2;
    localparam logic [1:0] FOP_DIV = 2'd3;

    localparam word_t QNAN_WORD  = 32'hFFC0_0000;
    localparam word_t QUIET_BIT  = 32'h0040_0000;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } fpu_req_t;

    typedef struct packed {
        logic  done;
        word_t value;
    } fpu_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/faofs_ram.sv @@
// Generic single-port RAM with a registered read.
`default_nettype none

module faofs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/faofs_fpu.sv @@
// Multi-cycle IEEE single-precision add, subtract, multiply and divide unit.
`default_nettype none

module faofs_fpu (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire faofs_pkg::fpu_req_t req,
    input  wire faofs_pkg::word_t    a,
    input  wire faofs_pkg::word_t    b,
    output faofs_pkg::fpu_rsp_t      rsp
);

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_PRE  = 4'd1;
    localparam logic [3:0] F_ADD  = 4'd2;
    localparam logic [3:0] F_MUL  = 4'd3;
    localparam logic [3:0] F_MULP = 4'd4;
    localparam logic [3:0] F_DIV  = 4'd5;
    localparam logic [3:0] F_DIVF = 4'd6;
    localparam logic [3:0] F_NORM = 4'd7;
    localparam logic [3:0] F_RND  = 4'd8;
    localparam logic [3:0] F_DONE = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic               sa_reg, sa_next, sb_reg, sb_next, sg_reg, sg_next;
    logic signed [11:0] ea_reg, ea_next, eb_reg, eb_next, ex_reg, ex_next;
    logic [23:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [27:0]        acc_reg, acc_next;
    logic [47:0]        prod_reg, prod_next;
    logic [27:0]        q_reg, q_next;
    logic [25:0]        rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    faofs_pkg::word_t   res_reg, res_next;

    // Operand classification.
    logic [7:0]  a_exp, b_exp;
    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, bs_eff, sx;
    logic        spec_hit;
    faofs_pkg::word_t spec_val;

    assign a_exp  = a[30:23];
    assign b_exp  = b[30:23];
    assign a_nan  = (&a_exp) && (|a[22:0]);
    assign a_inf  = (&a_exp) && !(|a[22:0]);
    assign a_zero = !(|a[30:0]);
    assign b_nan  = (&b_exp) && (|b[22:0]);
    assign b_inf  = (&b_exp) && !(|b[22:0]);
    assign b_zero = !(|b[30:0]);
    assign bs_eff = b[31] ^ (req.op == faofs_pkg::FOP_SUB);
    assign sx     = a[31] ^ b[31];

    // Results that need no arithmetic: NaNs, infinities and zeros.
    always_comb begin
        spec_hit = 1'b1;
        spec_val = '0;
        unique case (req.op) inside
            faofs_pkg::FOP_ADD, faofs_pkg::FOP_SUB: begin
                if (a_nan) begin
                    spec_val = a | faofs_pkg::QUIET_BIT;
                end else if (b_nan) begin
                    spec_val = b | faofs_pkg::QUIET_BIT;
                end else if (a_inf && b_inf && (a[31] != bs_eff)) begin
                    spec_val = faofs_pkg::QNAN_WORD;
                end else if (a_inf) begin
                    spec_val = a;
                end else if (b_inf) begin
                    spec_val = {bs_eff, b[30:0]};
                end else if (a_zero && b_zero) begin
                    spec_val = {a[31] & bs_eff, 31'd0};
                end else if (a_zero) begin
                    spec_val = {bs_eff, b[30:0]};
                end else if (b_zero) begin
                    spec_val = a;
                end else begin
                    spec_hit = 1'b0;
                end
            end
            faofs_pkg::FOP_MUL: begin
                if (a_nan) begin
                    spec_val = a | faofs_pkg::QUIET_BIT;
                end else if (b_nan) begin
                    spec_val = b | faofs_pkg::QUIET_BIT;
                end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                    spec_val = faofs_pkg::QNAN_WORD;
                end else if (a_inf || b_inf) begin
                    spec_val = {sx, 8'hFF, 23'd0};
                end else if (a_zero || b_zero) begin
                    spec_val = {sx, 31'd0};
                end else begin
                    spec_hit = 1'b0;
                end
            end
            default: begin
                if (a_nan) begin
                    spec_val = a | faofs_pkg::QUIET_BIT;
                end else if (b_nan) begin
                    spec_val = b | faofs_pkg::QUIET_BIT;
                end else if (a_inf && b_inf) begin
                    spec_val = faofs_pkg::QNAN_WORD;
                end else if (a_inf || b_zero) begin
                    spec_val = {sx, 8'hFF, 23'd0};
                end else if (b_inf || a_zero) begin
                    spec_val = {sx, 31'd0};
                end else begin
                    spec_hit = 1'b0;
                end
            end
        endcase
    end

    // Alignment for the add path.
    logic               a_big, s_big;
    logic signed [11:0] e_big, e_small, diff;
    logic [23:0]        m_big, m_small;
    logic [26:0]        sm_ext, al;
    logic [27:0]        sum;

    always_comb begin
        a_big   = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
        e_big   = a_big ? ea_reg : eb_reg;
        e_small = a_big ? eb_reg : ea_reg;
        m_big   = a_big ? ma_reg : mb_reg;
        m_small = a_big ? mb_reg : ma_reg;
        s_big   = a_big ? sa_reg : sb_reg;
        diff    = e_big - e_small;
        sm_ext  = {m_small, 3'b000};
        if (diff >= 12'sd27) begin
            al = 27'd1;
        end else begin
            al = (sm_ext >> diff[4:0])
               | 27'(|(sm_ext & ((27'd1 << diff[4:0]) - 27'd1)));
        end
        if (sa_reg != sb_reg) begin
            sum = {1'b0, m_big, 3'b000} - {1'b0, al};
        end else begin
            sum = {1'b0, m_big, 3'b000} + {1'b0, al};
        end
    end

    // Rounding to nearest even, with denormalization of tiny results.
    logic [11:0]      sh;
    logic [26:0]      rm, rm2;
    logic [7:0]       expf;
    logic             inc;
    logic [30:0]      packed_mag;

    always_comb begin
        rm = acc_reg[26:0];
        sh = 12'(12'sd1 - ex_reg);
        if (ex_reg <= 12'sd0) begin
            expf = 8'd0;
            if (sh >= 12'd27) begin
                rm2 = {26'd0, |rm};
            end else begin
                rm2 = (rm >> sh[4:0]) | 27'(|(rm & ((27'd1 << sh[4:0]) - 27'd1)));
            end
        end else begin
            expf = ex_reg[7:0];
            rm2  = rm;
        end
        inc        = rm2[2] & (rm2[3] | rm2[1] | rm2[0]);
        packed_mag = {expf, rm2[25:3]} + 31'(inc);
    end

    logic div_ge;
    logic [25:0] rem_sub;

    assign div_ge  = rem_reg >= {2'b00, mb_reg};
    assign rem_sub = div_ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        sg_next    = sg_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        ex_next    = ex_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (req.start) begin
                    op_next = req.op;
                    sa_next = a[31];
                    sb_next = bs_eff;
                    ea_next = (a_exp == 8'd0) ? 12'sd1 : signed'({4'd0, a_exp});
                    eb_next = (b_exp == 8'd0) ? 12'sd1 : signed'({4'd0, b_exp});
                    ma_next = {(a_exp != 8'd0), a[22:0]};
                    mb_next = {(b_exp != 8'd0), b[22:0]};
                    if (spec_hit) begin
                        res_next   = spec_val;
                        state_next = F_DONE;
                    end else begin
                        state_next = F_PRE;
                    end
                end
            end
            F_PRE: begin
                // Subnormal inputs are shifted up one bit a cycle.
                if (!ma_reg[23]) begin
                    ma_next = {ma_reg[22:0], 1'b0};
                    ea_next = ea_reg - 12'sd1;
                end
                if (!mb_reg[23]) begin
                    mb_next = {mb_reg[22:0], 1'b0};
                    eb_next = eb_reg - 12'sd1;
                end
                if (ma_reg[23] && mb_reg[23]) begin
                    rem_next = {2'b00, ma_reg};
                    q_next   = '0;
                    cnt_next = '0;
                    unique case (op_reg) inside
                        faofs_pkg::FOP_ADD, faofs_pkg::FOP_SUB: state_next = F_ADD;
                        faofs_pkg::FOP_MUL: state_next = F_MUL;
                        default:            state_next = F_DIV;
                    endcase
                end
            end
            F_ADD: begin
                if (sum == 28'd0) begin
                    res_next   = '0;
                    state_next = F_DONE;
                end else begin
                    acc_next   = sum;
                    ex_next    = e_big;
                    sg_next    = s_big;
                    state_next = F_NORM;
                end
            end
            F_MUL: begin
                prod_next  = ma_reg * mb_reg;
                ex_next    = ea_reg + eb_reg - 12'sd127;
                sg_next    = sa_reg ^ sb_reg;
                state_next = F_MULP;
            end
            F_MULP: begin
                acc_next   = {prod_reg[47:21], |prod_reg[20:0]};
                state_next = F_NORM;
            end
            F_DIV: begin
                rem_next = {rem_sub[24:0], 1'b0};
                q_next   = {q_reg[26:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd27) begin
                    state_next = F_DIVF;
                end
            end
            F_DIVF: begin
                acc_next   = {q_reg[27:1], q_reg[0] | (|rem_reg)};
                ex_next    = ea_reg - eb_reg + 12'sd126;
                sg_next    = sa_reg ^ sb_reg;
                state_next = F_NORM;
            end
            F_NORM: begin
                if (acc_reg[27]) begin
                    acc_next = {1'b0, acc_reg[27:2], acc_reg[1] | acc_reg[0]};
                    ex_next  = ex_reg + 12'sd1;
                end else if (!acc_reg[26]) begin
                    acc_next = {acc_reg[26:0], 1'b0};
                    ex_next  = ex_reg - 12'sd1;
                end else begin
                    state_next = F_RND;
                end
            end
            F_RND: begin
                if (ex_reg >= 12'sd255) begin
                    res_next = {sg_reg, 8'hFF, 23'd0};
                end else begin
                    res_next = {sg_reg, packed_mag};
                end
                state_next = F_DONE;
            end
            F_DONE: begin
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg   <= op_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        sg_reg   <= sg_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        ex_reg   <= ex_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign rsp.done  = (state_reg == F_DONE);
    assign rsp.value = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/float_alu_operand_fetch_store.sv @@
// Top level: operand fetch, float execute and store for one simulated GPU thread.
//
// Input words arrive on s_tvalid/s_tready; s_tuser carries the kind (execute,
// host write, host read), s_tdata the instruction fields. Each word yields one
// result word on m_tvalid/m_tready: m_tdata holds the value, m_tuser the status.
// The register file, shared store and global store each sit in a single-port
// RAM with a registered read; the two operands are read one after the other
// through those ports, then the result is written back through the same port.
// A host write skips the operand reads; host reads and failed words skip the
// write-back, and mov and neg skip the float unit. The float unit answers a NaN,
// infinity or zero at once, takes longer for add, sub and mul with subnormal
// inputs or a long cancellation, and resolves div one quotient bit per cycle.
// One word is in flight at a time; the next one is taken while a finished result
// still waits in the output register. Reset clears the register-file valid bits,
// so registers read as zero until written, and empties the output register.
// Shared and global words must be read only after being written; the block does
// not enforce this. When the receiver stalls, the result holds in the output
// register and the block stops before its next result.
`default_nettype none

module float_alu_operand_fetch_store #(
    parameter int REG_COUNT    = 32,
    parameter int SHARED_WORDS = 256,
    parameter int GLOBAL_WORDS = 1024
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // opcode, lhs_space, lhs_index, lhs_const, rhs_space, rhs_index, rhs_const,
    // dst_space, dst_index, host_data; zero pad at the top
    input  wire logic [135:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_value
    output logic [31:0]       m_tdata,
    // status
    output logic [2:0]        m_tuser
);

    localparam int RF_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int SH_AW = (SHARED_WORDS > 1) ? $clog2(SHARED_WORDS) : 1;
    localparam int GL_AW = (GLOBAL_WORDS > 1) ? $clog2(GLOBAL_WORDS) : 1;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_RDA  = 3'd1;
    localparam logic [2:0] T_RDB  = 3'd2;
    localparam logic [2:0] T_RDC  = 3'd3;
    localparam logic [2:0] T_CHK  = 3'd4;
    localparam logic [2:0] T_FPU  = 3'd5;
    localparam logic [2:0] T_WR   = 3'd6;
    localparam logic [2:0] T_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;

    // Latched instruction.
    logic [1:0]       kind_reg;
    logic [2:0]       opcode_reg;
    logic [1:0]       lspace_reg, rspace_reg, dspace_reg;
    logic [9:0]       lidx_reg, ridx_reg, didx_reg;
    faofs_pkg::word_t lconst_reg, rconst_reg, hdata_reg;

    faofs_pkg::word_t a_reg, a_next, b_reg, b_next;
    faofs_pkg::word_t wdata_reg, wdata_next, value_reg, value_next;
    logic [2:0]       status_reg, status_next;

    logic             m_valid_reg, m_valid_next;
    faofs_pkg::word_t m_data_reg, m_data_next;
    logic [2:0]       m_user_reg, m_user_next;

    logic [REG_COUNT-1:0] rf_valid_reg;
    logic                 rf_vld_q_reg;

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == T_IDLE);

    function automatic logic in_range(input logic [1:0] sp, input logic [9:0] idx);
        logic ok;
        unique case (sp)
            faofs_pkg::SPACE_REG:    ok = 32'(idx) < 32'(REG_COUNT);
            faofs_pkg::SPACE_GLOBAL: ok = 32'(idx) < 32'(GLOBAL_WORDS);
            faofs_pkg::SPACE_SHARED: ok = 32'(idx) < 32'(SHARED_WORDS);
            default:                 ok = 1'b1;
        endcase
        return ok;
    endfunction

    // Memory port address: left operand, right operand, then destination.
    logic [9:0] cur_idx;
    always_comb begin
        unique case (state_reg)
            T_RDA:   cur_idx = lidx_reg;
            T_RDB:   cur_idx = ridx_reg;
            default: cur_idx = didx_reg;
        endcase
    end

    logic wr_en, rf_we, sh_we, gl_we;
    assign wr_en = (state_reg == T_WR);
    assign rf_we = wr_en && (dspace_reg == faofs_pkg::SPACE_REG);
    assign gl_we = wr_en && (dspace_reg == faofs_pkg::SPACE_GLOBAL);
    assign sh_we = wr_en && (dspace_reg == faofs_pkg::SPACE_SHARED);

    logic [RF_AW-1:0] rf_addr;
    logic [SH_AW-1:0] sh_addr;
    logic [GL_AW-1:0] gl_addr;
    faofs_pkg::word_t rf_rdata, sh_rdata, gl_rdata;

    assign rf_addr = RF_AW'(cur_idx);
    assign sh_addr = SH_AW'(cur_idx);
    assign gl_addr = GL_AW'(cur_idx);

    faofs_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
        .aclk(aclk), .we(rf_we), .addr(rf_addr), .wdata(wdata_reg), .rdata(rf_rdata)
    );
    faofs_ram #(.WIDTH(32), .DEPTH(SHARED_WORDS)) u_shared (
        .aclk(aclk), .we(sh_we), .addr(sh_addr), .wdata(wdata_reg), .rdata(sh_rdata)
    );
    faofs_ram #(.WIDTH(32), .DEPTH(GLOBAL_WORDS)) u_global (
        .aclk(aclk), .we(gl_we), .addr(gl_addr), .wdata(wdata_reg), .rdata(gl_rdata)
    );

    // Operand as read from its space; an unwritten register reads as zero.
    logic [1:0]       f_space;
    faofs_pkg::word_t f_const, fetched;
    assign f_space = (state_reg == T_RDB) ? lspace_reg : rspace_reg;
    assign f_const = (state_reg == T_RDB) ? lconst_reg : rconst_reg;

    always_comb begin
        unique case (f_space)
            faofs_pkg::SPACE_CONST:  fetched = f_const;
            faofs_pkg::SPACE_REG:    fetched = rf_vld_q_reg ? rf_rdata : '0;
            faofs_pkg::SPACE_GLOBAL: fetched = gl_rdata;
            default:                 fetched = sh_rdata;
        endcase
    end

    logic lhs_ok, rhs_ok, dst_ok, dst_const;
    assign lhs_ok    = in_range(lspace_reg, lidx_reg);
    assign rhs_ok    = in_range(rspace_reg, ridx_reg);
    assign dst_ok    = in_range(dspace_reg, didx_reg);
    assign dst_const = (dspace_reg == faofs_pkg::SPACE_CONST);

    faofs_pkg::fpu_req_t fpu_req;
    faofs_pkg::fpu_rsp_t fpu_rsp;
    logic                fpu_start;
    logic [1:0]          fpu_op;

    always_comb begin
        unique case (opcode_reg) inside
            faofs_pkg::OP_ADD: fpu_op = faofs_pkg::FOP_ADD;
            faofs_pkg::OP_SUB: fpu_op = faofs_pkg::FOP_SUB;
            faofs_pkg::OP_MUL: fpu_op = faofs_pkg::FOP_MUL;
            default:           fpu_op = faofs_pkg::FOP_DIV;
        endcase
    end

    assign fpu_req = '{start: fpu_start, op: fpu_op};

    faofs_fpu u_fpu (
        .aclk(aclk), .aresetn(aresetn), .req(fpu_req), .a(a_reg), .b(b_reg), .rsp(fpu_rsp)
    );

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        wdata_next   = wdata_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        fpu_start    = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == faofs_pkg::KIND_HWRITE) ? T_CHK : T_RDA;
                end
            end
            T_RDA: state_next = T_RDB;
            T_RDB: begin
                a_next     = fetched;
                state_next = T_RDC;
            end
            T_RDC: begin
                b_next     = fetched;
                state_next = T_CHK;
            end
            T_CHK: begin
                status_next = faofs_pkg::ST_OK;
                value_next  = '0;
                state_next  = T_OUT;
                case (kind_reg)
                    faofs_pkg::KIND_HWRITE: begin
                        if (dst_const) begin
                            status_next = faofs_pkg::ST_CONSTDST;
                        end else if (!dst_ok) begin
                            status_next = faofs_pkg::ST_RANGE;
                        end else begin
                            wdata_next = hdata_reg;
                            state_next = T_WR;
                        end
                    end
                    faofs_pkg::KIND_HREAD: begin
                        if (!lhs_ok) begin
                            status_next = faofs_pkg::ST_RANGE;
                        end else begin
                            value_next = a_reg;
                        end
                    end
                    faofs_pkg::KIND_EXEC: begin
                        // Operand range first, then opcode, divisor, destination.
                        if (!lhs_ok || !rhs_ok) begin
                            status_next = faofs_pkg::ST_RANGE;
                        end else if (opcode_reg > faofs_pkg::OP_NEG) begin
                            status_next = faofs_pkg::ST_BADOP;
                        end else if ((opcode_reg == faofs_pkg::OP_DIV) && !(|b_reg[30:0])) begin
                            status_next = faofs_pkg::ST_DIVZERO;
                        end else if (dst_const) begin
                            status_next = faofs_pkg::ST_CONSTDST;
                        end else if (!dst_ok) begin
                            status_next = faofs_pkg::ST_RANGE;
                        end else if (opcode_reg == faofs_pkg::OP_MOV) begin
                            wdata_next = b_reg;
                            value_next = b_reg;
                            state_next = T_WR;
                        end else if (opcode_reg == faofs_pkg::OP_NEG) begin
                            wdata_next = {~b_reg[31], b_reg[30:0]};
                            value_next = {~b_reg[31], b_reg[30:0]};
                            state_next = T_WR;
                        end else begin
                            fpu_start  = 1'b1;
                            state_next = T_FPU;
                        end
                    end
                    default: begin
                        status_next = faofs_pkg::ST_BADOP;
                    end
                endcase
            end
            T_FPU: begin
                if (fpu_rsp.done) begin
                    wdata_next = fpu_rsp.value;
                    value_next = fpu_rsp.value;
                    state_next = T_WR;
                end
            end
            T_WR: state_next = T_OUT;
            T_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = value_reg;
                    m_user_next  = status_reg;
                    state_next   = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            m_valid_reg  <= 1'b0;
            rf_valid_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (rf_we) begin
                rf_valid_reg[rf_addr] <= 1'b1;
            end
        end
        if (accept) begin
            kind_reg   <= s_tuser;
            opcode_reg <= s_tdata[2:0];
            lspace_reg <= s_tdata[4:3];
            lidx_reg   <= s_tdata[14:5];
            lconst_reg <= s_tdata[46:15];
            rspace_reg <= s_tdata[48:47];
            ridx_reg   <= s_tdata[58:49];
            rconst_reg <= s_tdata[90:59];
            dspace_reg <= s_tdata[92:91];
            didx_reg   <= s_tdata[102:93];
            hdata_reg  <= s_tdata[134:103];
        end
        rf_vld_q_reg <= rf_valid_reg[rf_addr];
        a_reg        <= a_next;
        b_reg        <= b_next;
        wdata_reg    <= wdata_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

@@ hw/rtl/faofs_checker.sv @@
// Port-level checks of the float ALU operand fetch and store block, bound to the top level.
`default_nettype none

module faofs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // A stalled result word keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Any error status comes with a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != faofs_pkg::ST_OK) |-> (m_tdata == 32'd0))
        else $error("error result carries a nonzero value");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One word is worked on at a time: no accept in the cycle after an accept.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in flight");

endmodule

bind float_alu_operand_fetch_store faofs_checker u_faofs_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the float ALU operand fetch and store block.
`timescale 1ns / 1ps

module tb;
    import faofs_pkg::*;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;
    localparam int NUM_REGS = 32;
    localparam int NUM_SHARED = 256;
    localparam int NUM_GLOBAL = 1024;
    localparam int RANDOM_ITEMS = 1030;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic       pad;
        word_t      host_data;
        logic [9:0] dst_index;
        logic [1:0] dst_space;
        word_t      rhs_const;
        logic [9:0] rhs_index;
        logic [1:0] rhs_space;
        word_t      lhs_const;
        logic [9:0] lhs_index;
        logic [1:0] lhs_space;
        logic [2:0] opcode;
    } instr_t;

    typedef struct packed {
        logic [1:0] kind;
        instr_t     fields;
    } item_t;

    typedef struct packed {
        word_t      value;
        logic [2:0] status;
    } outcome_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [2:0]   m_tuser;

    float_alu_operand_fetch_store dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state, kept in step with the accepted words.
    word_t reg_model[NUM_REGS];
    word_t shared_model[NUM_SHARED];
    word_t global_model[NUM_GLOBAL];

    item_t    pending_items[$];
    outcome_t expected_results[$];
    item_t    offered;
    int       error_count = 0;
    int       results_seen = 0;
    int       cycle_count = 0;

    // Stimulus-side record of which memory words hold data, so no read of an
    // unwritten shared or global word is ever generated.
    bit shared_written[NUM_SHARED];
    bit global_written[NUM_GLOBAL];
    int shared_list[$];
    int global_list[$];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Single-precision value widened to double; NaN is handled by the caller.
    function automatic real single_to_real(word_t w);
        real r;
        if (w[30:23] == 8'hFF)
            return $bitstoreal({w[31], 11'h7FF, 52'd0});
        if (w[30:23] == 8'h00) begin
            r = real'(w[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
            return w[31] ? -r : r;
        end
        return $bitstoreal({w[31], 11'(w[30:23]) + 11'd896, w[22:0], 29'd0});
    endfunction

    // Double narrowed to single with round to nearest even.
    function automatic word_t real_to_single(real r);
        logic [63:0] b;
        logic [63:0] sig, q, rem, half, v;
        int exp_val, sh;
        b = $realtobits(r);
        if (b[62:52] == 11'd0)
            return {b[63], 31'd0};
        if (b[62:52] == 11'h7FF)
            return {b[63], 8'hFF, 23'd0};
        exp_val = int'(b[62:52]) - 1023;
        sig = {11'd0, 1'b1, b[51:0]};
        sh = (exp_val >= -126) ? 29 : 29 + (-126 - exp_val);
        if (sh > 60)
            sh = 60;
        q = sig >> sh;
        rem = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        if (exp_val >= -126) begin
            if (exp_val > 127)
                v = 64'h7F80_0000;
            else
                v = (64'(exp_val + 126) << 23) + q;
            if (v >= 64'h7F80_0000)
                v = 64'h7F80_0000;
        end else begin
            v = q;
        end
        return {b[63], v[30:0]};
    endfunction

    function automatic word_t float_arith(logic [2:0] op, word_t a, word_t b);
        bit nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        real x, y, r;
        nan_a = a[30:23] == 8'hFF && a[22:0] != 0;
        nan_b = b[30:23] == 8'hFF && b[22:0] != 0;
        inf_a = a[30:0] == 31'h7F80_0000;
        inf_b = b[30:0] == 31'h7F80_0000;
        zero_a = a[30:0] == 0;
        zero_b = b[30:0] == 0;
        if (nan_a)
            return a | QUIET_BIT;
        if (nan_b)
            return b | QUIET_BIT;
        case (op)
            OP_ADD: if (inf_a && inf_b && a[31] != b[31]) return QNAN_WORD;
            OP_SUB: if (inf_a && inf_b && a[31] == b[31]) return QNAN_WORD;
            OP_MUL: if ((inf_a && zero_b) || (zero_a && inf_b)) return QNAN_WORD;
            default: if (inf_a && inf_b) return QNAN_WORD;
        endcase
        x = single_to_real(a);
        y = single_to_real(b);
        case (op)
            OP_ADD: r = x + y;
            OP_SUB: r = x - y;
            OP_MUL: r = x * y;
            default: r = x / y;
        endcase
        return real_to_single(r);
    endfunction

    // Looks up a word; false when the index lies outside the space.
    function automatic bit read_space(logic [1:0] space, logic [9:0] idx, word_t cval,
                                      output word_t w);
        w = '0;
        case (space)
            SPACE_CONST: w = cval;
            SPACE_REG: begin
                if (idx >= NUM_REGS) return 0;
                w = reg_model[idx];
            end
            SPACE_GLOBAL: w = global_model[idx];
            default: begin
                if (idx >= NUM_SHARED) return 0;
                w = shared_model[idx];
            end
        endcase
        return 1;
    endfunction

    // Stores a word; returns the status of the attempt.
    function automatic logic [2:0] write_space(logic [1:0] space, logic [9:0] idx, word_t w);
        case (space)
            SPACE_CONST: return ST_CONSTDST;
            SPACE_REG: begin
                if (idx >= NUM_REGS) return ST_RANGE;
                reg_model[idx] = w;
            end
            SPACE_GLOBAL: global_model[idx] = w;
            default: begin
                if (idx >= NUM_SHARED) return ST_RANGE;
                shared_model[idx] = w;
            end
        endcase
        return ST_OK;
    endfunction

    function automatic outcome_t execute_item(item_t it);
        instr_t f;
        word_t a, b, r;
        outcome_t res;
        f = it.fields;
        res = '0;
        case (it.kind)
            KIND_HWRITE: res.status = write_space(f.dst_space, f.dst_index, f.host_data);
            KIND_HREAD: begin
                if (!read_space(f.lhs_space, f.lhs_index, f.lhs_const, res.value))
                    res.status = ST_RANGE;
            end
            KIND_EXEC: begin
                if (!read_space(f.lhs_space, f.lhs_index, f.lhs_const, a) ||
                    !read_space(f.rhs_space, f.rhs_index, f.rhs_const, b)) begin
                    res.status = ST_RANGE;
                end else if (f.opcode > OP_NEG) begin
                    res.status = ST_BADOP;
                end else if (f.opcode == OP_DIV && b[30:0] == 0) begin
                    res.status = ST_DIVZERO;
                end else begin
                    if (f.opcode == OP_MOV)
                        r = b;
                    else if (f.opcode == OP_NEG)
                        r = b ^ 32'h8000_0000;
                    else
                        r = float_arith(f.opcode, a, b);
                    res.status = write_space(f.dst_space, f.dst_index, r);
                    res.value = r;
                end
            end
            default: res.status = ST_BADOP;
        endcase
        if (res.status != ST_OK)
            res.value = '0;
        return res;
    endfunction

    function automatic word_t rand_float();
        word_t specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h7F7F_FFFF,
                                32'h3F80_0000, 32'h807F_FFFF};
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
            6, 7: return specials[$urandom_range(0, 9)];
            8: return {1'($urandom), 8'd0, 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(250, 254)), 23'($urandom)};
        endcase
    endfunction

    task automatic add_item(logic [1:0] kind, logic [2:0] op,
                            logic [1:0] ls, logic [9:0] li, word_t lc,
                            logic [1:0] rs, logic [9:0] ri, word_t rc,
                            logic [1:0] ds, logic [9:0] di, word_t hd);
        item_t it;
        it.kind = kind;
        it.fields = '{1'b0, hd, di, ds, rc, ri, rs, lc, li, ls, op};
        pending_items.push_back(it);
        if (kind == KIND_HWRITE) begin
            if (ds == SPACE_GLOBAL && !global_written[di]) begin
                global_written[di] = 1;
                global_list.push_back(di);
            end
            if (ds == SPACE_SHARED && di < NUM_SHARED && !shared_written[di]) begin
                shared_written[di] = 1;
                shared_list.push_back(di);
            end
        end
    endtask

    // Picks a source space and index whose read is legal to issue.
    task automatic pick_source(output logic [1:0] space, output logic [9:0] idx);
        space = 2'($urandom_range(0, 3));
        idx = 10'($urandom);
        case (space)
            SPACE_REG: if ($urandom_range(0, 9) != 0) idx = 10'($urandom_range(0, NUM_REGS - 1));
            SPACE_GLOBAL: begin
                if (global_list.size() == 0) space = SPACE_CONST;
                else idx = 10'(global_list[$urandom_range(0, global_list.size() - 1)]);
            end
            SPACE_SHARED: begin
                if ($urandom_range(0, 9) == 0) idx = 10'($urandom_range(NUM_SHARED, 1023));
                else if (shared_list.size() == 0) space = SPACE_CONST;
                else idx = 10'(shared_list[$urandom_range(0, shared_list.size() - 1)]);
            end
            default: ;
        endcase
    endtask

    task automatic pick_dest(output logic [1:0] space, output logic [9:0] idx);
        space = 2'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
        idx = 10'($urandom);
        if (space == SPACE_REG && $urandom_range(0, 9) != 0)
            idx = 10'($urandom_range(0, NUM_REGS - 1));
        if (space == SPACE_SHARED && $urandom_range(0, 9) != 0)
            idx = 10'($urandom_range(0, NUM_SHARED - 1));
    endtask

    task automatic build_stimulus();
        logic [1:0] ls, rs, ds, kind;
        logic [9:0] li, ri, di;
        int pick;
        // Registers read as zero after reset, host read of a constant.
        add_item(KIND_HREAD, OP_ADD, SPACE_REG, 10'd0, '0, 0, 0, '0, 0, 0, '0);
        add_item(KIND_HREAD, OP_ADD, SPACE_CONST, 10'd1023, 32'hFFFF_FFFF, 0, 0, '0, 0, 0, '0);
        // Host writes: every space, range and constant destination errors.
        add_item(KIND_HWRITE, OP_ADD, 0, 0, '0, 0, 0, '0, SPACE_SHARED, 10'd255, 32'h4000_0000);
        add_item(KIND_HWRITE, OP_ADD, 0, 0, '0, 0, 0, '0, SPACE_GLOBAL, 10'd1023, 32'hFFFF_FFFF);
        add_item(KIND_HWRITE, OP_ADD, 0, 0, '0, 0, 0, '0, SPACE_GLOBAL, 10'd0, 32'h8000_0000);
        add_item(KIND_HWRITE, OP_ADD, 0, 0, '0, 0, 0, '0, SPACE_REG, 10'd31, 32'h3F80_0000);
        add_item(KIND_HWRITE, OP_ADD, 0, 0, '0, 0, 0, '0, SPACE_CONST, 10'd0, 32'h1234_5678);
        add_item(KIND_HWRITE, OP_ADD, 0, 0, '0, 0, 0, '0, SPACE_REG, 10'd32, 32'h1234_5678);
        add_item(KIND_HWRITE, OP_ADD, 0, 0, '0, 0, 0, '0, SPACE_SHARED, 10'd256, 32'h1);
        add_item(KIND_HREAD, OP_ADD, SPACE_SHARED, 10'd255, '0, 0, 0, '0, 0, 0, '0);
        add_item(KIND_HREAD, OP_ADD, SPACE_SHARED, 10'd1023, '0, 0, 0, '0, 0, 0, '0);
        add_item(KIND_HREAD, OP_ADD, SPACE_GLOBAL, 10'd1023, '0, 0, 0, '0, 0, 0, '0);
        // Every opcode from mixed spaces.
        add_item(KIND_EXEC, OP_ADD, SPACE_REG, 10'd31, '0, SPACE_SHARED, 10'd255, '0,
                 SPACE_REG, 10'd1, '0);
        add_item(KIND_EXEC, OP_SUB, SPACE_GLOBAL, 10'd0, '0, SPACE_CONST, 10'd1023,
                 32'h0000_0000, SPACE_GLOBAL, 10'd5, '0);
        add_item(KIND_EXEC, OP_MUL, SPACE_CONST, 0, 32'h7F7F_FFFF, SPACE_CONST, 0, 32'h4000_0000,
                 SPACE_SHARED, 10'd0, '0);
        add_item(KIND_EXEC, OP_DIV, SPACE_CONST, 0, 32'h3F80_0000, SPACE_REG, 10'd1, '0,
                 SPACE_REG, 10'd2, '0);
        add_item(KIND_EXEC, OP_MOV, SPACE_CONST, 0, '0, SPACE_CONST, 0, 32'h7F80_0001,
                 SPACE_REG, 10'd3, '0);
        add_item(KIND_EXEC, OP_NEG, SPACE_CONST, 0, '0, SPACE_REG, 10'd3, '0, SPACE_REG, 10'd4, '0);
        // Error cases: divide by plus and minus zero, bad opcodes, bad indexes,
        // constant destination, invalid operation.
        add_item(KIND_EXEC, OP_DIV, SPACE_CONST, 0, 32'h3F80_0000, SPACE_CONST, 0, 32'h8000_0000,
                 SPACE_REG, 10'd5, '0);
        add_item(KIND_EXEC, OP_DIV, SPACE_CONST, 0, '0, SPACE_REG, 10'd7, '0, SPACE_REG, 10'd5, '0);
        add_item(KIND_EXEC, OP_BAD6, SPACE_CONST, 0, '0, SPACE_CONST, 0, '0, SPACE_REG, 0, '0);
        add_item(KIND_EXEC, OP_BAD7, SPACE_REG, 10'd40, '0, SPACE_CONST, 0, '0, SPACE_REG, 0, '0);
        add_item(KIND_EXEC, OP_MOV, SPACE_CONST, 0, '0, SPACE_SHARED, 10'd300, '0,
                 SPACE_REG, 0, '0);
        add_item(KIND_EXEC, OP_SUB, SPACE_CONST, 0, 32'h7F80_0000, SPACE_CONST, 0, 32'h7F80_0000,
                 SPACE_CONST, 0, '0);
        add_item(KIND_EXEC, OP_ADD, SPACE_CONST, 0, 32'h7F80_0000, SPACE_CONST, 0, 32'hFF80_0000,
                 SPACE_REG, 10'd40, '0);
        add_item(KIND_UNKNOWN, OP_ADD, 0, 0, '0, 0, 0, '0, SPACE_REG, 10'd6, 32'hDEAD_BEEF);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            kind = pick < 62 ? KIND_EXEC : pick < 82 ? KIND_HWRITE :
                   pick < 97 ? KIND_HREAD : KIND_UNKNOWN;
            pick_source(ls, li);
            pick_source(rs, ri);
            pick_dest(ds, di);
            add_item(kind, 3'($urandom_range(0, 19) == 0 ? $urandom_range(6, 7)
                                                         : $urandom_range(0, 5)),
                     ls, li, rand_float(), rs, ri, rand_float(), ds, di, rand_float());
        end
    endtask

    // Sender: bursts of words with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(execute_item(offered));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    offered = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= offered.fields;
                    s_tuser <= offered.kind;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern picked at random from three modes; one long hold-off lets
    // the block fill up while the sender keeps offering words.
    int stall_mode = 0;
    int holdoff_left = 0;
    bit holdoff_done = 0;
    always @(posedge aclk) begin
        if (cycle_count % 64 == 0)
            stall_mode = $urandom_range(0, 2);
        if (!holdoff_done && results_seen >= 300) begin
            holdoff_done = 1;
            holdoff_left = 400;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= $urandom_range(0, 4) != 0;
            endcase
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word value %h status %0d",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: value mismatch: expected %h, actual %h",
                             $time, want.value, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        aresetn = 1'b0;
        foreach (reg_model[i]) reg_model[i] = '0;
        foreach (shared_model[i]) shared_model[i] = '0;
        foreach (global_model[i]) global_model[i] = '0;
        build_stimulus();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
